// File: design/uart_frame_receiver_top_macros.svh
// Assertion macros used by the frame parser module.
// Every check is sampled on the rising clock edge and is ignored while reset is held.
`ifndef UART_FRAME_RECEIVER_TOP_MACROS_SVH
`define UART_FRAME_RECEIVER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame receiver check failed");

// The consequent must hold in the cycle after the antecedent.
`define UFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame receiver check failed");

`endif

// File: design/ufr_pkg.sv
package ufr_pkg;

  // Field widths of the byte stream and the frame header.
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned CFG_IDX_W = 4;

  // Hard ceiling on the payload length, whatever the register says.
  localparam logic [LEN_W-1:0] MAX_PAYLOAD = 16'd64;

  // Reset values of the configuration registers.
  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hF8;
  localparam logic [CNT_W-1:0]  MAX_LEN_RST      = 7'd64;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 4'd1;

  // Frame parsing phases.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_OPCODE  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC_LO  = 3'd5,
    PH_CRC_HI  = 3'd6
  } ufr_phase_t;

  // Event codes reported for each byte.
  typedef enum logic [EV_W-1:0] {
    EV_HEADER     = 3'd0,
    EV_DATA       = 3'd1,
    EV_DONE       = 3'd2,
    EV_BAD_MARKER = 3'd3,
    EV_BAD_OPCODE = 3'd4,
    EV_BAD_LENGTH = 3'd5
  } ufr_event_t;

  // One result beat.
  typedef struct packed {
    ufr_event_t         event_res;
    logic [BYTE_W-1:0]  data_byte;
    logic [IDX_W-1:0]   payload_index;
    logic [BYTE_W-1:0]  frame_opcode;
    logic [LEN_W-1:0]   frame_length;
    logic [LEN_W-1:0]   frame_crc;
  } ufr_result_t;

  // Opcodes that a frame may carry.
  localparam int unsigned NUM_OPCODES = 12;
  localparam logic [BYTE_W-1:0] OPCODE_TABLE [NUM_OPCODES] = '{
    8'h00, 8'h13, 8'h31, 8'h22, 8'h37, 8'h54,
    8'h56, 8'h64, 8'h59, 8'h32, 8'h52, 8'h62
  };

  function automatic logic opcode_known(input logic [BYTE_W-1:0] op);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_OPCODES; i++) begin
      if (OPCODE_TABLE[i] == op) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// File: design/uart_frame_receiver_top.sv
// A byte is registered in the input register, and its event beat is then registered in the result register.
// Throughput: one byte per cycle while the result side does not stall; the frame state register updates once per byte.
// Backpressure on the result side stalls the input only when both registers are full.
// Reset (rst_n low, synchronous) empties both stages, returns the receiver to hunting
// for the start marker and restores the configuration registers to their defaults.
module uart_frame_receiver_top
  import ufr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [EV_W-1:0]      out_event_res,
  output logic [BYTE_W-1:0]    out_data_byte,
  output logic [IDX_W-1:0]     out_payload_index,
  output logic [BYTE_W-1:0]    out_frame_opcode,
  output logic [LEN_W-1:0]     out_frame_length,
  output logic [LEN_W-1:0]     out_frame_crc
);

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_data;
  logic              take;
  logic              res_ready;
  ufr_result_t       res;
  ufr_result_t       out_res;

  // Input register.
  ufr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (take),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  // Frame state machine and configuration.
  ufr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .res_ready  (res_ready),
    .take       (take),
    .res        (res)
  );

  // Result register.
  ufr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (take),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_event_res     = out_res.event_res;
  assign out_data_byte     = out_res.data_byte;
  assign out_payload_index = out_res.payload_index;
  assign out_frame_opcode  = out_res.frame_opcode;
  assign out_frame_length  = out_res.frame_length;
  assign out_frame_crc     = out_res.frame_crc;

endmodule

// File: design/ufr_in_stage.sv
module ufr_in_stage
  import ufr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_rx_byte,
  input  logic              take,
  output logic              byte_valid,
  output logic [BYTE_W-1:0] byte_data
);

  logic              valid_r, valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic              load;

  // The register refills whenever it is empty or its beat moves on.
  assign load     = !valid_r || take;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

endmodule

// File: design/ufr_parser.sv
`include "uart_frame_receiver_top_macros.svh"

module ufr_parser
  import ufr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  input  logic                 byte_valid,
  input  logic [BYTE_W-1:0]    byte_data,
  input  logic                 res_ready,
  output logic                 take,
  output ufr_result_t          res
);

  logic [BYTE_W-1:0] marker_r;
  logic [CNT_W-1:0]  max_len_r;

  ufr_phase_t        phase_r, phase_nxt;
  logic [BYTE_W-1:0] opcode_r, opcode_nxt;
  logic [LEN_W-1:0]  length_r, length_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BYTE_W-1:0] crc_lo_r, crc_lo_nxt;

  logic [LEN_W-1:0]  limit;
  logic [LEN_W-1:0]  len_full;
  logic [CNT_W-1:0]  count_inc;
  logic              hide;

  // A byte is consumed when the result register can take its beat.
  assign take = byte_valid && res_ready;

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r  <= START_MARKER_RST;
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_START_MARKER) begin
        marker_r <= cfg_wdata;
      end
      if (cfg_index == CFG_MAX_LEN) begin
        max_len_r <= cfg_wdata[CNT_W-1:0];
      end
    end
  end

  // Effective length limit is the smaller of the register and the hard ceiling.
  assign limit     = (MAX_PAYLOAD < {{(LEN_W-CNT_W){1'b0}}, max_len_r}) ?
                     MAX_PAYLOAD : {{(LEN_W-CNT_W){1'b0}}, max_len_r};
  assign len_full  = {byte_data, length_r[BYTE_W-1:0]};
  assign count_inc = count_r + 1'b1;

  // Next state and result for the byte at the head of the input register.
  always_comb begin
    phase_nxt         = phase_r;
    opcode_nxt        = opcode_r;
    length_nxt        = length_r;
    count_nxt         = count_r;
    crc_lo_nxt        = crc_lo_r;
    hide              = 1'b0;
    res.event_res     = EV_HEADER;
    res.data_byte     = '0;
    res.payload_index = '0;
    res.frame_crc     = '0;
    unique case (phase_r)
      PH_OPCODE: begin
        opcode_nxt = byte_data;
        if (opcode_known(byte_data)) begin
          phase_nxt = PH_LEN_LO;
        end else begin
          res.event_res = EV_BAD_OPCODE;
          phase_nxt     = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        length_nxt = {{(LEN_W-BYTE_W){1'b0}}, byte_data};
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = len_full;
        if (len_full <= limit) begin
          count_nxt = '0;
          phase_nxt = (len_full == '0) ? PH_CRC_LO : PH_PAYLOAD;
        end else begin
          res.event_res = EV_BAD_LENGTH;
          phase_nxt     = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        res.event_res     = EV_DATA;
        res.data_byte     = byte_data;
        res.payload_index = count_r[IDX_W-1:0];
        count_nxt         = count_inc;
        if ({{(LEN_W-CNT_W){1'b0}}, count_inc} >= length_r) begin
          phase_nxt = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_nxt = byte_data;
        phase_nxt  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        res.event_res = EV_DONE;
        res.frame_crc = {byte_data, crc_lo_r};
        phase_nxt     = PH_HUNT;
      end
      default: begin
        // Hunting for the start marker; an unused phase code behaves the same.
        if (byte_data == marker_r) begin
          opcode_nxt = '0;
          length_nxt = '0;
          phase_nxt  = PH_OPCODE;
        end else begin
          res.event_res = EV_BAD_MARKER;
          hide          = 1'b1;
          phase_nxt     = PH_HUNT;
        end
      end
    endcase
    res.frame_opcode = hide ? '0 : opcode_nxt;
    res.frame_length = hide ? '0 : length_nxt;
  end

  // Frame state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      opcode_r <= '0;
      length_r <= '0;
      count_r  <= '0;
      crc_lo_r <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  // The payload counter never runs past the accepted length.
  `UFR_ASSERT_IMPL(a_count_in_range, phase_r == PH_PAYLOAD, LEN_W'(count_r) < length_r)
  // The high length byte is only ever expected straight after the low one.
  `UFR_ASSERT_IMPL(a_len_hi_order, phase_r == PH_LEN_HI && $changed(phase_r), $past(phase_r) == PH_LEN_LO)
  // A CRC is reported only with a completed frame.
  `UFR_ASSERT_IMPL(a_crc_only_done, take && res.event_res != EV_DONE, res.frame_crc == '0)
  // A complete frame always returns the receiver to hunting.
  `UFR_ASSERT_NEXT(a_done_hunts, take && res.event_res == EV_DONE, phase_r == PH_HUNT)

endmodule

// File: design/ufr_out_stage.sv
module ufr_out_stage
  import ufr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  ufr_result_t res,
  output logic        res_ready,
  output logic        out_valid,
  input  logic        out_stall,
  output ufr_result_t out_res
);

  logic        valid_r, valid_nxt;
  ufr_result_t res_r;

  // The result register takes a new beat when empty or when its beat is taken.
  assign res_ready = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (res_ready) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

import ufr_pkg::*;

// Keeps a bit-level model of the frame parser, holds the event beats that it
// predicts and compares each beat from the block against the oldest one.
class frame_scoreboard;
  ufr_phase_t          phase;
  logic [BYTE_W-1:0]   opcode_q;
  logic [LEN_W-1:0]    length_q;
  logic [CNT_W-1:0]    count_q;
  logic [BYTE_W-1:0]   crc_lo_q;
  logic [BYTE_W-1:0]   marker_q;
  logic [CNT_W-1:0]    max_len_q;
  ufr_result_t         expected_q[$];
  int unsigned         mismatches;

  function new();
    phase      = PH_HUNT;
    opcode_q   = '0;
    length_q   = '0;
    count_q    = '0;
    crc_lo_q   = '0;
    marker_q   = START_MARKER_RST;
    max_len_q  = MAX_LEN_RST;
    mismatches = 0;
  endfunction

  // Indexes past the register list are ignored by the block.
  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] data);
    case (idx)
      CFG_START_MARKER: marker_q = data;
      CFG_MAX_LEN:      max_len_q = data[CNT_W-1:0];
      default: ;
    endcase
  endfunction

  // The register can ask for more than the hard ceiling; the smaller one wins.
  function logic [LEN_W-1:0] len_limit();
    logic [LEN_W-1:0] reg_len;
    reg_len = LEN_W'(max_len_q);
    return (reg_len > MAX_PAYLOAD) ? MAX_PAYLOAD : reg_len;
  endfunction

  function bit allowed_op(logic [BYTE_W-1:0] op);
    bit hit;
    hit = 1'b0;
    foreach (OPCODE_TABLE[i]) begin
      if (OPCODE_TABLE[i] == op) hit = 1'b1;
    end
    return hit;
  endfunction

  function bit hunting();
    return phase == PH_HUNT;
  endfunction

  // Advances the parser by one accepted byte and queues the event it causes.
  function void note_byte(logic [BYTE_W-1:0] b);
    ufr_result_t r;
    bit          hide;
    r         = '0;
    r.event_res = EV_HEADER;
    hide      = 1'b0;
    case (phase)
      PH_OPCODE: begin
        opcode_q = b;
        if (allowed_op(b)) begin
          phase = PH_LEN_LO;
        end else begin
          r.event_res = EV_BAD_OPCODE;
          phase = PH_HUNT;
        end
      end
      PH_LEN_LO: begin
        length_q = LEN_W'(b);
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_q = {b, length_q[BYTE_W-1:0]};
        if (length_q <= len_limit()) begin
          count_q = '0;
          phase = (length_q == '0) ? PH_CRC_LO : PH_PAYLOAD;
        end else begin
          r.event_res = EV_BAD_LENGTH;
          phase = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        r.event_res = EV_DATA;
        r.data_byte = b;
        r.payload_index = count_q[IDX_W-1:0];
        count_q = count_q + 1'b1;
        if (LEN_W'(count_q) >= length_q) phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_lo_q = b;
        phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        r.event_res = EV_DONE;
        r.frame_crc = {b, crc_lo_q};
        phase = PH_HUNT;
      end
      default: begin
        // Hunting for the marker, or an unused phase code.
        if (b == marker_q) begin
          opcode_q = '0;
          length_q = '0;
          phase = PH_OPCODE;
        end else begin
          r.event_res = EV_BAD_MARKER;
          hide = 1'b1;
          phase = PH_HUNT;
        end
      end
    endcase
    r.frame_opcode = hide ? '0 : opcode_q;
    r.frame_length = hide ? '0 : length_q;
    expected_q.push_back(r);
  endfunction

  task report(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Compares one event beat from the block with the oldest prediction.
  task check_beat(ufr_result_t got);
    ufr_result_t want;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected beat, event %0d", got.event_res));
    end else begin
      want = expected_q.pop_front();
      if (got.event_res != want.event_res)
        report($sformatf("event %0d, expected %0d", got.event_res, want.event_res));
      if (got.data_byte != want.data_byte)
        report($sformatf("data_byte %0h, expected %0h", got.data_byte, want.data_byte));
      if (got.payload_index != want.payload_index)
        report($sformatf("payload_index %0d, expected %0d",
                         got.payload_index, want.payload_index));
      if (got.frame_opcode != want.frame_opcode)
        report($sformatf("frame_opcode %0h, expected %0h",
                         got.frame_opcode, want.frame_opcode));
      if (got.frame_length != want.frame_length)
        report($sformatf("frame_length %0h, expected %0h",
                         got.frame_length, want.frame_length));
      if (got.frame_crc != want.frame_crc)
        report($sformatf("frame_crc %0h, expected %0h", got.frame_crc, want.frame_crc));
    end
  endtask
endclass

module tb;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASE_BYTES    = 92;
  localparam int unsigned NUM_PHASES     = 8;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_IDX = {CFG_IDX_W{1'b1}};

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [BYTE_W-1:0]    in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [EV_W-1:0]      out_event_res;
  logic [BYTE_W-1:0]    out_data_byte;
  logic [IDX_W-1:0]     out_payload_index;
  logic [BYTE_W-1:0]    out_frame_opcode;
  logic [LEN_W-1:0]     out_frame_length;
  logic [LEN_W-1:0]     out_frame_crc;

  frame_scoreboard sb;
  int unsigned     idle_pct;
  int unsigned     stall_pct;
  bit              hold_req;
  int unsigned     quiet_cycles;

  uart_frame_receiver_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_res     (out_event_res),
    .out_data_byte     (out_data_byte),
    .out_payload_index (out_payload_index),
    .out_frame_opcode  (out_frame_opcode),
    .out_frame_length  (out_frame_length),
    .out_frame_crc     (out_frame_crc)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: checks every accepted beat and drives the stall, with an
  // occasional long hold-off so that the block backs up into its input.
  initial begin
    ufr_result_t got;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.event_res     = ufr_event_t'(out_event_res);
        got.data_byte     = out_data_byte;
        got.payload_index = out_payload_index;
        got.frame_opcode  = out_frame_opcode;
        got.frame_length  = out_frame_length;
        got.frame_crc     = out_frame_crc;
        sb.check_beat(got);
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no beat moves on either side for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Offers one byte after a random idle gap and waits for it to be taken.
  task send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid   <= 1'b0;
      in_rx_byte <= BYTE_W'($urandom);
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_byte(b);
  endtask

  // Raises the enable for the write and lowers it again before returning, so back-to-back
  // writes never drive the enable twice at the same edge.
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  // Stops offering and waits until every predicted beat has come out.
  task drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random content; the rest are stray bytes,
  // bad opcodes and lengths beyond the limit.
  task send_random_frame(output int unsigned nbytes);
    int unsigned       kind;
    int unsigned       len;
    int unsigned       lim;
    logic [BYTE_W-1:0] op;
    logic [LEN_W-1:0]  len_field;
    nbytes = 0;
    // Flush any partial frame left by stray bytes that matched the marker.
    while (!sb.hunting()) begin
      send_byte(BYTE_W'($urandom));
      nbytes++;
    end
    kind = $urandom_range(99);
    if (kind < 10) begin
      send_byte(BYTE_W'($urandom));
      nbytes++;
      return;
    end
    send_byte(sb.marker_q);
    nbytes++;
    if (kind < 18) begin
      do op = BYTE_W'($urandom); while (sb.allowed_op(op));
      send_byte(op);
      nbytes++;
      return;
    end
    send_byte(OPCODE_TABLE[$urandom_range(NUM_OPCODES-1)]);
    nbytes++;
    lim = 32'(sb.len_limit());
    if (kind < 26) begin
      if ($urandom_range(1)) len_field = {BYTE_W'($urandom_range(1, 255)), BYTE_W'($urandom)};
      else len_field = LEN_W'($urandom_range(lim + 1, 255));
      send_byte(len_field[BYTE_W-1:0]);
      send_byte(len_field[LEN_W-1:BYTE_W]);
      nbytes += 2;
      return;
    end
    if (kind < 34) len = lim;
    else len = $urandom_range(0, (lim < 8) ? lim : 8);
    len_field = LEN_W'(len);
    send_byte(len_field[BYTE_W-1:0]);
    send_byte(len_field[LEN_W-1:BYTE_W]);
    repeat (len) send_byte(BYTE_W'($urandom));
    send_byte(BYTE_W'($urandom));
    send_byte(BYTE_W'($urandom));
    nbytes += 4 + len;
  endtask

  initial begin
    int unsigned       sent;
    int unsigned       n;
    logic [BYTE_W-1:0] marker_w;
    logic [BYTE_W-1:0] len_w;
    sb = new();
    rst_n      = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    out_stall  = 1'b0;
    idle_pct   = 0;
    stall_pct  = 0;
    hold_req   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bytes under the reset settings: stray bytes at both extremes,
    // a zero-length frame, an unknown opcode, a length one past the ceiling
    // and a one-byte payload.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_MARKER_RST);
    send_byte(OPCODE_TABLE[0]);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(START_MARKER_RST);
    send_byte(8'hFF);
    send_byte(START_MARKER_RST);
    send_byte(OPCODE_TABLE[NUM_OPCODES-1]);
    send_byte(BYTE_W'(MAX_PAYLOAD + 1));
    send_byte(8'h00);
    send_byte(START_MARKER_RST);
    send_byte(OPCODE_TABLE[1]);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        case (p)
          1: begin marker_w = 8'h00; len_w = 8'h00; end
          2: begin marker_w = 8'hFF; len_w = 8'hFF; end
          3: begin marker_w = BYTE_W'($urandom); len_w = {1'($urandom), 7'd64}; end
          4: begin
            marker_w = BYTE_W'($urandom);
            len_w = {1'($urandom), 7'($urandom_range(1, 16))};
          end
          default: begin marker_w = BYTE_W'($urandom); len_w = BYTE_W'($urandom); end
        endcase
        write_reg(CFG_START_MARKER, marker_w);
        write_reg(CFG_MAX_LEN, len_w);
        if (p == 3 || p == 6) begin
          write_reg(CFG_IDX_W'($urandom_range(int'(CFG_MAX_LEN) + 1, int'(CFG_LAST_IDX))),
                    BYTE_W'($urandom));
        end
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      // Back-to-back bytes against a long hold-off fill the block up.
      if (p == 4) hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        send_random_frame(n);
        sent += n;
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
